// ----- rtl/ipdr_pkg.sv -----
// shared constants and types for the iscsi pdu receive deframer
`timescale 1ns / 1ps

package ipdr_pkg;

    localparam int HEADER_BYTES = 48;

    localparam logic [1:0] SEC_BHS  = 2'd0;
    localparam logic [1:0] SEC_AHS  = 2'd1;
    localparam logic [1:0] SEC_DATA = 2'd2;
    localparam logic [1:0] SEC_PAD  = 2'd3;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [1:0]  section;
        logic [23:0] section_offset;
        logic        section_last;
        logic        pdu_end;
        logic [5:0]  pdu_opcode;
        logic [23:0] data_length;
        logic        segment_end;
    } res_t;

endpackage

// ----- rtl/ipdr_frame_core.sv -----
// framing state and per-byte tag logic
`timescale 1ns / 1ps

module ipdr_frame_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    rx_byte,
    input  logic          segment_last,
    output ipdr_pkg::res_t res
);
    import ipdr_pkg::*;

    logic [1:0]  sec_reg, sec_next;
    logic [23:0] off_reg, off_next;
    logic [7:0]  ahs_reg, ahs_next;
    logic [23:0] seg_reg, seg_next;
    logic [5:0]  opc_reg, opc_next;

    logic [24:0] off_inc;
    logic [24:0] sec_len;
    logic [1:0]  pad;
    logic        last;
    logic        end_flag;
    logic [1:0]  nxt;
    logic        ahs_nz, seg_nz, pad_nz;

    always_comb
    begin
        opc_next = opc_reg;
        ahs_next = ahs_reg;
        seg_next = seg_reg;
        if (sec_reg == SEC_BHS)
        begin
            case (off_reg)
                24'd0:
                begin
                    opc_next = rx_byte[5:0];
                    ahs_next = '0;
                    seg_next = '0;
                end
                24'd4: ahs_next = rx_byte;
                24'd5: seg_next[23:16] = rx_byte;
                24'd6: seg_next[15:8] = rx_byte;
                24'd7: seg_next[7:0] = rx_byte;
                default: ;
            endcase
        end

        pad     = 2'd0 - seg_next[1:0];
        off_inc = {1'b0, off_reg} + 25'd1;

        case (sec_reg)
            SEC_BHS:  sec_len = 25'(HEADER_BYTES);
            SEC_AHS:  sec_len = {15'd0, ahs_next, 2'b00};
            SEC_DATA: sec_len = {1'b0, seg_next};
            default:  sec_len = {23'd0, pad};
        endcase
        last = (off_inc >= sec_len);

        ahs_nz = (ahs_next != 8'd0);
        seg_nz = (seg_next != 24'd0);
        pad_nz = (pad != 2'd0);

        end_flag = 1'b0;
        nxt      = SEC_BHS;
        case (sec_reg)
            SEC_BHS:
            begin
                if (ahs_nz)
                    nxt = SEC_AHS;
                else if (seg_nz)
                    nxt = SEC_DATA;
                else if (pad_nz)
                    nxt = SEC_PAD;
                else
                    end_flag = 1'b1;
            end
            SEC_AHS:
            begin
                if (seg_nz)
                    nxt = SEC_DATA;
                else if (pad_nz)
                    nxt = SEC_PAD;
                else
                    end_flag = 1'b1;
            end
            SEC_DATA:
            begin
                if (pad_nz)
                    nxt = SEC_PAD;
                else
                    end_flag = 1'b1;
            end
            default: end_flag = 1'b1;
        endcase

        sec_next = last ? nxt : sec_reg;
        off_next = last ? 24'd0 : off_inc[23:0];

        res.byte_out       = rx_byte;
        res.section        = sec_reg;
        res.section_offset = off_reg;
        res.section_last   = last;
        res.pdu_end        = last && end_flag;
        res.pdu_opcode     = opc_next;
        res.data_length    = seg_next;
        res.segment_end    = segment_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg <= SEC_BHS;
            off_reg <= '0;
            ahs_reg <= '0;
            seg_reg <= '0;
            opc_reg <= '0;
        end
        else if (accept)
        begin
            sec_reg <= sec_next;
            off_reg <= off_next;
            ahs_reg <= ahs_next;
            seg_reg <= seg_next;
            opc_reg <= opc_next;
        end
    end

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.pdu_end |-> res.section_last)
        else $error("pdu end without section end");

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.pdu_end |=> sec_reg == SEC_BHS && off_reg == 24'd0)
        else $error("pdu end did not restart header");

    a_mid_section: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !res.section_last |=>
            $stable(sec_reg) && off_reg == $past(off_reg) + 24'd1)
        else $error("offset did not advance within section");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(sec_reg) && $stable(off_reg) && $stable(seg_reg))
        else $error("framing state moved without a transaction");

endmodule

// ----- rtl/ipdr_out_reg.sv -----
// result register between framing logic and output stream
`timescale 1ns / 1ps

module ipdr_out_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ipdr_pkg::res_t in_res,
    output logic           out_valid,
    input  logic           out_ready,
    output ipdr_pkg::res_t out_res
);
    import ipdr_pkg::*;

    logic valid_reg;
    res_t res_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            res_reg <= in_res;
    end

endmodule

// ----- rtl/iscsi_pdu_rx_deframer_unit.sv -----
// top level of the iscsi pdu receive deframer
//
// s_axis carries the received tcp byte stream, one byte per transaction in
// tdata, with tlast marking the last byte of a delivered chunk. m_axis
// returns each byte tagged with its pdu section, section offset, latched
// opcode and latched data length; tlast marks the byte that ends a pdu.
// one output transaction follows every input transaction, in order.
// the output is valid in the cycle after the input transaction. throughput
// is one byte per cycle while the receiver does not stall: the framing
// state updates in the same cycle the byte is taken and the tags land in a
// single result register. when the receiver stalls, the result register
// holds and s_axis_tready drops until the result is taken; tready returns
// in the cycle the result leaves, so no bubble is added. reset clears the
// framing state to the start of a basic header and empties the result
// register; no byte is dropped or repeated across a stall.
`timescale 1ns / 1ps

module iscsi_pdu_rx_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tlast,   // segment_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // byte_out, section_offset, pdu_opcode, data_length
    output logic [3:0]  m_axis_tuser,   // section, section_last, segment_end
    output logic        m_axis_tlast    // pdu_end
);
    import ipdr_pkg::*;

    res_t core_res;
    res_t out_res;
    logic accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    ipdr_frame_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .rx_byte      (s_axis_tdata),
        .segment_last (s_axis_tlast),
        .res          (core_res)
    );

    ipdr_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_res    (core_res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {2'b00, out_res.data_length, out_res.pdu_opcode,
                           out_res.section_offset, out_res.byte_out};
    assign m_axis_tuser = {out_res.segment_end, out_res.section_last, out_res.section};
    assign m_axis_tlast = out_res.pdu_end;

endmodule

// ----- tb/ipdr_stream_checker.sv -----
// predicts and checks every output transaction of the iscsi pdu receive deframer
`timescale 1ns / 1ps

module ipdr_stream_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tlast,   // segment_last
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,   // byte_out, section_offset, pdu_opcode, data_length
    input  logic [3:0]  m_axis_tuser,   // section, section_last, segment_end
    input  logic        m_axis_tlast,   // pdu_end
    output int          errors,
    output int          pending,
    output int          n_checked,
    output int          n_pdus
);
    import ipdr_pkg::*;

    logic [1:0]  cur_sec;
    logic [23:0] cur_off;
    logic [7:0]  ahs_words;
    logic [23:0] seg_len;
    logic [5:0]  opc_latch;

    res_t tagged_q[$];

    initial
    begin
        cur_sec   = SEC_BHS;
        cur_off   = '0;
        ahs_words = '0;
        seg_len   = '0;
        opc_latch = '0;
        errors    = 0;
        pending   = 0;
        n_checked = 0;
        n_pdus    = 0;
    end

    function automatic int sec_len(input logic [1:0] s);
        case (s)
            SEC_BHS:  return HEADER_BYTES;
            SEC_AHS:  return 4 * int'(ahs_words);
            SEC_DATA: return int'(seg_len);
            default:  return (4 - int'(seg_len[1:0])) % 4;
        endcase
    endfunction

    task automatic tag_byte(input logic [7:0] b, input logic mark, output res_t r);
        logic [1:0]  sec;
        logic [23:0] off;
        logic        last;
        logic        ends;
        int          nxt;
        sec  = cur_sec;
        off  = cur_off;
        ends = 1'b0;
        if (sec == SEC_BHS)
        begin
            case (off)
                24'd0:
                begin
                    opc_latch = b[5:0];
                    ahs_words = '0;
                    seg_len   = '0;
                end
                24'd4: ahs_words     = b;
                24'd5: seg_len[23:16] = b;
                24'd6: seg_len[15:8]  = b;
                24'd7: seg_len[7:0]   = b;
                default: ;
            endcase
        end
        last = (int'(off) + 1 >= sec_len(sec));
        if (last)
        begin
            nxt = int'(sec) + 1;
            while (nxt < 4 && sec_len(2'(nxt)) == 0)
                nxt++;
            if (nxt >= 4)
            begin
                ends = 1'b1;
                nxt  = 0;
            end
            cur_sec = 2'(nxt);
            cur_off = '0;
        end
        else
        begin
            cur_off = off + 24'd1;
        end
        r.byte_out       = b;
        r.section        = sec;
        r.section_offset = off;
        r.section_last   = last;
        r.pdu_end        = ends;
        r.pdu_opcode     = opc_latch;
        r.data_length    = seg_len;
        r.segment_end    = mark;
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
        end
    endtask

    // handshake signals are stable from negedge to the next rising edge
    always @(negedge clk)
    begin
        res_t want;
        res_t got;
        if (rst_n === 1'b1)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                tag_byte(s_axis_tdata, s_axis_tlast, want);
                tagged_q.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.byte_out       = m_axis_tdata[7:0];
                got.section_offset = m_axis_tdata[31:8];
                got.pdu_opcode     = m_axis_tdata[37:32];
                got.data_length    = m_axis_tdata[61:38];
                got.section        = m_axis_tuser[1:0];
                got.section_last   = m_axis_tuser[2];
                got.segment_end    = m_axis_tuser[3];
                got.pdu_end        = m_axis_tlast;
                if (tagged_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transaction, expected none actual 0x%0h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    want = tagged_q.pop_front();
                    check_field("byte_out", 64'(want.byte_out), 64'(got.byte_out));
                    check_field("section", 64'(want.section), 64'(got.section));
                    check_field("section_offset", 64'(want.section_offset),
                                64'(got.section_offset));
                    check_field("section_last", 64'(want.section_last),
                                64'(got.section_last));
                    check_field("pdu_end", 64'(want.pdu_end), 64'(got.pdu_end));
                    check_field("pdu_opcode", 64'(want.pdu_opcode), 64'(got.pdu_opcode));
                    check_field("data_length", 64'(want.data_length),
                                64'(got.data_length));
                    check_field("segment_end", 64'(want.segment_end),
                                64'(got.segment_end));
                    n_checked++;
                    if (want.pdu_end)
                        n_pdus++;
                end
            end
            pending = tagged_q.size();
        end
    end

endmodule

// ----- tb/iscsi_pdu_rx_deframer_unit_tb.sv -----
// stimulus and verdict for the iscsi pdu receive deframer
`timescale 1ns / 1ps

module iscsi_pdu_rx_deframer_unit_tb;

    import ipdr_pkg::*;

    localparam int WD_LIMIT   = 2000;
    localparam int RAND_ITEMS = 500;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int src_idle;
    int snk_idle;
    int n_sent;
    int wd_cnt;
    int errors;
    int pending;
    int n_checked;
    int n_pdus;

    iscsi_pdu_rx_deframer_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    ipdr_stream_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (errors),
        .pending       (pending),
        .n_checked     (n_checked),
        .n_pdus        (n_pdus)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= snk_idle);

    always @(negedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                wd_cnt <= 0;
            else
                wd_cnt <= wd_cnt + 1;
            if (wd_cnt >= WD_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic mark);
        logic took;
        if (n_sent < 200)
        begin
            src_idle = 10;
            snk_idle = 68;
        end
        else if (n_sent < 400)
        begin
            src_idle = 68;
            snk_idle = 10;
        end
        else
        begin
            src_idle = 0;
            snk_idle = 0;
        end
        while ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= mark;
        do
        begin
            @(negedge clk);
            took = s_axis_tready;
            @(posedge clk);
        end
        while (!took);
        n_sent++;
    endtask

    // sends one pdu, cut short after max_len bytes
    task automatic send_pdu(input logic [7:0] b0, input logic [7:0] ahs,
                            input logic [23:0] dlen, input int max_len);
        logic [7:0] hdr[HEADER_BYTES];
        logic [7:0] b;
        int         ahs_end;
        int         data_end;
        int         total;
        for (int i = 0; i < HEADER_BYTES; i++)
            hdr[i] = 8'($urandom);
        hdr[0]   = b0;
        hdr[4]   = ahs;
        hdr[5]   = dlen[23:16];
        hdr[6]   = dlen[15:8];
        hdr[7]   = dlen[7:0];
        ahs_end  = HEADER_BYTES + 4 * int'(ahs);
        data_end = ahs_end + int'(dlen);
        total    = data_end + (4 - int'(dlen[1:0])) % 4;
        for (int i = 0; i < total && i < max_len; i++)
        begin
            if (i < HEADER_BYTES)
                b = hdr[i];
            else if (i < data_end)
                b = 8'($urandom);
            else
                b = 8'h00;
            send_byte(b, $urandom_range(7) == 0);
        end
    endtask

    initial
    begin
        logic [7:0]  ahs;
        logic [23:0] dlen;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        src_idle      = 10;
        snk_idle      = 68;
        n_sent        = 0;
        wd_cnt        = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // header only, with all-ones opcode byte
        send_pdu(8'hFF, 8'd0, 24'd0, 1 << 30);
        // additional header, one data byte, three pad bytes
        send_pdu(8'h00, 8'd1, 24'd1, 1 << 30);
        // two pad bytes, no additional header
        send_pdu(8'h40, 8'd0, 24'd2, 1 << 30);
        // one pad byte
        send_pdu(8'h81, 8'd2, 24'd3, 1 << 30);
        // data ends the pdu without padding
        send_pdu(8'h3F, 8'd0, 24'd4, 1 << 30);
        // additional header ends the pdu
        send_pdu(8'hC0, 8'd1, 24'd0, 1 << 30);

        while (n_sent < RAND_ITEMS)
        begin
            ahs  = ($urandom_range(9) == 0) ? 8'($urandom_range(16)) : 8'($urandom_range(2));
            dlen = ($urandom_range(9) == 0) ? 24'($urandom_range(200))
                                            : 24'($urandom_range(12));
            send_pdu(8'($urandom), ahs, dlen, 1 << 30);
        end

        // oversized lengths, truncated before the data segment completes
        send_pdu(8'($urandom), 8'hFF, 24'hFFFFFF, HEADER_BYTES + 40);

        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("checked %0d tagged bytes, %0d pdus ended, across three flow-control mixes",
                 n_checked, n_pdus);
        $display("stimulus: edge-case pdus, random pdus, and a truncated oversized pdu");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
